/* design/cpig_pkg.sv */
// Shared widths and register index codes for the conv2d patch index generator.
`timescale 1ns / 1ps

package cpig_pkg;

    localparam int OUT_W     = 24;
    localparam int KROW_W    = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_ROWS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COLS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_STEP = 3'd5;

endpackage

/* design/cpig_div.sv */
// Restoring serial divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module cpig_div #(
    parameter int DIM_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIM_BITS-1:0] dividend,
    input  logic [DIM_BITS-1:0] divisor,
    output logic                done,
    output logic [DIM_BITS-1:0] quotient
);

    localparam int CNT_W = (DIM_BITS > 1) ? $clog2(DIM_BITS) : 1;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIM_BITS-1:0] rem_reg, rem_next;
    logic [DIM_BITS-1:0] quot_reg, quot_next;
    logic [DIM_BITS-1:0] dvs_reg, dvs_next;
    logic [DIM_BITS:0]   shifted;
    logic [DIM_BITS:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIM_BITS-1]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIM_BITS])
            begin
                rem_next  = trial[DIM_BITS-1:0];
                quot_next = {quot_reg[DIM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DIM_BITS-1:0];
                quot_next = {quot_reg[DIM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* design/cpig_mac.sv */
// Registered multiply-add unit shared by every step of the index computation.
`timescale 1ns / 1ps

module cpig_mac #(
    parameter int DIM_BITS = 12
) (
    input  logic                       clk,
    input  logic [cpig_pkg::OUT_W-1:0] mul_a,
    input  logic [DIM_BITS-1:0]        mul_b,
    input  logic [cpig_pkg::OUT_W-1:0] add_c,
    output logic [cpig_pkg::OUT_W-1:0] result
);

    import cpig_pkg::*;

    logic [OUT_W-1:0]          result_reg, result_next;
    logic [OUT_W+DIM_BITS-1:0] product;

    always_comb
    begin
        product     = mul_a * mul_b;
        result_next = product[OUT_W-1:0] + add_c;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

/* design/conv2d_patch_index_generator.sv */
// Top level of the conv2d patch index generator with its sequencer.
//
//   channel   direction   word
//   in        sink        restart
//   out       source      start_index, window_number, kernel_row, last
//   cfg       sink        cfg_index, cfg_data (write only, no wait)
//
// A restart runs two passes of the serial divider, first for the vertical and then for the horizontal window count.
// An advance runs three passes through the shared multiply-add unit, in S_MUL_A, S_MUL_B and S_MUL_C, before S_OUT.
// The input is ready only while the sequencer is idle.
// A finished word waits in the output register while the next word is accepted.
// Reset clears the sequencer, the counters and the size registers, and sets both step registers to one.
`timescale 1ns / 1ps

module conv2d_patch_index_generator #(
    parameter int DIM_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cpig_pkg::OUT_W-1:0]     start_index,
    output logic [cpig_pkg::OUT_W-1:0]     window_number,
    output logic [cpig_pkg::KROW_W-1:0]    kernel_row,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [cpig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]            cfg_data
);

    import cpig_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV_V = 7'b0000010,
        S_DIV_H = 7'b0000100,
        S_MUL_A = 7'b0001000,
        S_MUL_B = 7'b0010000,
        S_MUL_C = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_BITS-1:0] in_rows_reg, in_cols_reg, k_rows_reg, k_cols_reg;
    logic [DIM_BITS-1:0] v_step_reg, h_step_reg;

    logic [DIM_BITS-1:0] wr_reg, wr_next;
    logic [DIM_BITS-1:0] wc_reg, wc_next;
    logic [DIM_BITS-1:0] kr_reg, kr_next;
    logic [DIM_BITS:0]   vc_reg, vc_next;
    logic [DIM_BITS:0]   hc_reg, hc_next;
    logic [OUT_W-1:0]    win_reg, win_next;
    logic                active_reg, active_next;

    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    idx_reg, idx_next;
    logic [OUT_W-1:0]    wnum_reg, wnum_next;
    logic [KROW_W-1:0]   krow_reg, krow_next;
    logic                last_reg, last_next;

    logic [DIM_BITS:0]   diff_v, diff_h;
    logic                ge_v, ge_h;
    logic [DIM_BITS-1:0] mag_v, mag_h;
    logic [DIM_BITS-1:0] v_div, h_div;
    logic                div_start, div_done;
    logic [DIM_BITS-1:0] div_dividend, div_divisor, div_quot;
    logic                ge_sel;
    logic [DIM_BITS:0]   count_new;

    logic [OUT_W-1:0]    mac_a, mac_c, mac_q;
    logic [DIM_BITS-1:0] mac_b;

    logic [DIM_BITS:0]   kr_inc, wc_inc, wr_inc;
    logic                final_entry;
    logic                in_accept, out_free;

    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        diff_v = {1'b0, in_rows_reg} - {1'b0, k_rows_reg};
        diff_h = {1'b0, in_cols_reg} - {1'b0, k_cols_reg};
        ge_v   = !diff_v[DIM_BITS];
        ge_h   = !diff_h[DIM_BITS];
        mag_v  = ge_v ? diff_v[DIM_BITS-1:0] : (k_rows_reg - in_rows_reg);
        mag_h  = ge_h ? diff_h[DIM_BITS-1:0] : (k_cols_reg - in_cols_reg);
        v_div  = (v_step_reg == '0) ? DIM_BITS'(1) : v_step_reg;
        h_div  = (h_step_reg == '0) ? DIM_BITS'(1) : h_step_reg;
        ge_sel = (state_reg == S_DIV_V) ? ge_v : ge_h;
        if (ge_sel)
        begin
            count_new = {1'b0, div_quot} + 1'b1;
        end
        else
        begin
            count_new = (div_quot == '0) ? (DIM_BITS+1)'(1) : '0;
        end
    end

    cpig_div #(
        .DIM_BITS (DIM_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    cpig_mac #(
        .DIM_BITS (DIM_BITS)
    ) u_mac (
        .clk    (clk),
        .mul_a  (mac_a),
        .mul_b  (mac_b),
        .add_c  (mac_c),
        .result (mac_q)
    );

    always_comb
    begin
        mac_a = OUT_W'(wr_reg);
        mac_b = v_step_reg;
        mac_c = OUT_W'(kr_reg);
        unique case (state_reg)
            S_MUL_B:
            begin
                mac_a = mac_q;
                mac_b = in_cols_reg;
                mac_c = '0;
            end
            S_MUL_C:
            begin
                mac_a = OUT_W'(wc_reg);
                mac_b = h_step_reg;
                mac_c = mac_q;
            end
            S_OUT:
            begin
                mac_a = '0;
                mac_b = '0;
                mac_c = mac_q;
            end
            default:
            begin
                mac_a = OUT_W'(wr_reg);
                mac_b = v_step_reg;
                mac_c = OUT_W'(kr_reg);
            end
        endcase
    end

    always_comb
    begin
        kr_inc      = {1'b0, kr_reg} + 1'b1;
        wc_inc      = {1'b0, wc_reg} + 1'b1;
        wr_inc      = {1'b0, wr_reg} + 1'b1;
        final_entry = (wr_inc >= vc_reg) && (wc_inc >= hc_reg)
                      && (kr_inc >= {1'b0, k_rows_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        wr_next        = wr_reg;
        wc_next        = wc_reg;
        kr_next        = kr_reg;
        vc_next        = vc_reg;
        hc_next        = hc_reg;
        win_next       = win_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        wnum_next      = wnum_reg;
        krow_next      = krow_reg;
        last_next      = last_reg;
        div_start      = 1'b0;
        div_dividend   = mag_v;
        div_divisor    = v_div;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (restart)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV_V;
                    end
                    else if (active_reg)
                    begin
                        if (kr_inc >= {1'b0, k_rows_reg})
                        begin
                            kr_next  = '0;
                            win_next = win_reg + 1'b1;
                            if (wc_inc >= hc_reg)
                            begin
                                wc_next = '0;
                                wr_next = (wr_inc >= vc_reg) ? '0 : wr_inc[DIM_BITS-1:0];
                            end
                            else
                            begin
                                wc_next = wc_inc[DIM_BITS-1:0];
                            end
                        end
                        else
                        begin
                            kr_next = kr_inc[DIM_BITS-1:0];
                        end
                        state_next = S_MUL_A;
                    end
                end
            end
            S_DIV_V:
            begin
                if (div_done)
                begin
                    vc_next      = count_new;
                    div_start    = 1'b1;
                    div_dividend = mag_h;
                    div_divisor  = h_div;
                    state_next   = S_DIV_H;
                end
            end
            S_DIV_H:
            begin
                if (div_done)
                begin
                    hc_next     = count_new;
                    wr_next     = '0;
                    wc_next     = '0;
                    kr_next     = '0;
                    win_next    = '0;
                    active_next = (vc_reg != '0) && (count_new != '0)
                                  && (k_rows_reg != '0);
                    state_next  = active_next ? S_MUL_A : S_IDLE;
                end
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = mac_q;
                    wnum_next      = win_reg;
                    krow_next      = KROW_W'(kr_reg);
                    last_next      = final_entry;
                    if (final_entry)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_reg        <= '0;
            wc_reg        <= '0;
            kr_reg        <= '0;
            vc_reg        <= '0;
            hc_reg        <= '0;
            win_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            wc_reg        <= wc_next;
            kr_reg        <= kr_next;
            vc_reg        <= vc_next;
            hc_reg        <= hc_next;
            win_reg       <= win_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        wnum_reg <= wnum_next;
        krow_reg <= krow_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rows_reg <= '0;
            in_cols_reg <= '0;
            k_rows_reg  <= '0;
            k_cols_reg  <= '0;
            v_step_reg  <= DIM_BITS'(1);
            h_step_reg  <= DIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INPUT_ROWS:      in_rows_reg <= cfg_data;
                CFG_INPUT_COLS:      in_cols_reg <= cfg_data;
                CFG_KERNEL_ROWS:     k_rows_reg  <= cfg_data;
                CFG_KERNEL_COLS:     k_cols_reg  <= cfg_data;
                CFG_VERTICAL_STEP:   v_step_reg  <= cfg_data;
                CFG_HORIZONTAL_STEP: h_step_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign start_index   = idx_reg;
    assign window_number = wnum_reg;
    assign kernel_row    = krow_reg;
    assign last          = last_reg;

endmodule

/* design/cpig_checker.sv */
// Port-level checker for the conv2d patch index generator and its bind.
`timescale 1ns / 1ps

module cpig_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           restart,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [cpig_pkg::OUT_W-1:0]     start_index,
    input logic [cpig_pkg::OUT_W-1:0]     window_number,
    input logic [cpig_pkg::KROW_W-1:0]    kernel_row,
    input logic                           last
);

    import cpig_pkg::*;

    // A restart runs the divider twice, so the input stays closed for a while.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && restart |=> !in_ready ##1 !in_ready)
        else $error("Input reopened too early after a restart.");

    // A waiting word holds its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_index)
            && $stable(window_number) && $stable(kernel_row) && $stable(last))
        else $error("Output word changed while stalled.");

    // No word is offered in the cycle after reset has been seen.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Output valid during reset.");

endmodule

bind conv2d_patch_index_generator cpig_checker u_cpig_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_index   (start_index),
    .window_number (window_number),
    .kernel_row    (kernel_row),
    .last          (last)
);
